### rtl/lkv_pkg.sv
`default_nettype none

package lkv_pkg;

  // Default geometry
  localparam int DEPTH_DEF      = 8;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Capacity register
  localparam int          CAP_W     = 4;
  localparam logic [3:0]  CAP_RESET = 4'd8;

  // Command codes
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_GET    = 1'b1
  } lkv_cmd_t;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic upd;    // commit the pending transaction this cycle
    logic hit;    // key found in one of the cells
    logic ins;    // pending command is an insert
    logic evict;  // insert miss drops the least recent entry
  } lkv_ctl_t;

endpackage

`default_nettype wire

### rtl/lkv_in_if.sv
`default_nettype none

interface lkv_in_if
  import lkv_pkg::*;
#(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic        [KEY_BITS-1:0]   key;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

`default_nettype wire

### rtl/lkv_out_if.sv
`default_nettype none

interface lkv_out_if
  import lkv_pkg::*;
#(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [VALUE_BITS-1:0] read_value;
  logic                         evicted;
  logic        [KEY_BITS-1:0]   mru_key;
  logic                         mru_valid;

  modport source (output valid, output hit, output read_value, output evicted,
                  output mru_key, output mru_valid, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input mru_key, input mru_valid, output ready);
endinterface

`default_nettype wire

### rtl/lkv_cell.sv
`default_nettype none

// One slot of the recency chain. Position in the chain is the recency rank:
// the cell nearest the head holds the most recent entry.
module lkv_cell
  import lkv_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int PW         = 3,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lkv_ctl_t                     ctl,
  input  wire logic        [PW-1:0]         hit_pos,
  input  wire logic                         cmp_en,
  input  wire logic        [KEY_BITS-1:0]   cmp_key,
  input  wire logic                         prev_valid,
  input  wire logic        [KEY_BITS-1:0]   prev_key,
  input  wire logic signed [VALUE_BITS-1:0] prev_value,
  output logic                              valid_r,
  output logic             [KEY_BITS-1:0]   key_r,
  output logic signed      [VALUE_BITS-1:0] value_r,
  output logic                              match_r
);

  logic shift;

  // On a hit, cells up to the hit slot move back one place; on an insert
  // miss, every occupied cell plus the first free one moves back. With an
  // eviction only the occupied cells move, so the last entry falls off.
  always_comb begin
    shift = 1'b0;
    if (ctl.upd) begin
      if (ctl.hit) begin
        shift = (PW'(IDX) <= hit_pos);
      end else if (ctl.ins) begin
        shift = valid_r | (prev_valid & ~ctl.evict);
      end
    end
  end

  // Control: valid bit and registered match line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (shift) begin
        valid_r <= prev_valid;
      end
      if (cmp_en) begin
        match_r <= valid_r & (key_r == cmp_key);
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (shift) begin
      key_r   <= prev_key;
      value_r <= prev_value;
    end
  end

endmodule

`default_nettype wire

### rtl/lru_key_value_cache_top.sv
`default_nettype none

// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    cmd, key, value
// out_ch    out  valid/ready    hit, read_value, evicted, mru_key, mru_valid
// cfg       in   cfg_we         cfg_data (capacity)
//
// A transaction is first latched, with the parallel key compare registered in every
// cell; then the recency chain shifts and the result register loads.
// in_ch.ready is high only between transactions.
// A full result register that is not taken holds the commit cycle.
// Synchronous active-low reset empties every cell; capacity resets to 8.
module lru_key_value_cache_top
  import lkv_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  lkv_in_if.sink           in_ch,
  lkv_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_t;

  state_t                       state_r, state_nxt;
  logic        [CAP_W-1:0]      cap_r;
  logic        [CW-1:0]         count_r;
  logic                         cmd_r;
  logic        [KEY_BITS-1:0]   key_r;
  logic signed [VALUE_BITS-1:0] value_r;

  logic                         out_valid_r;
  logic                         out_hit_r;
  logic signed [VALUE_BITS-1:0] out_read_value_r;
  logic                         out_evicted_r;
  logic        [KEY_BITS-1:0]   out_mru_key_r;
  logic                         out_mru_valid_r;

  logic                         cell_valid [DEPTH];
  logic        [KEY_BITS-1:0]   cell_key   [DEPTH];
  logic signed [VALUE_BITS-1:0] cell_value [DEPTH];
  logic                         cell_match [DEPTH];

  logic                         accept;
  logic                         out_free;
  logic                         commit;
  logic                         hit;
  logic        [PW-1:0]         hit_pos;
  logic signed [VALUE_BITS-1:0] hit_value;
  logic        [MW-1:0]         cap_eff;
  logic                         evict;
  logic                         is_ins;
  logic signed [VALUE_BITS-1:0] head_value;
  lkv_ctl_t                     ctl;

  assign accept   = in_ch.valid & in_ch.ready;
  assign out_free = ~out_valid_r | out_ch.ready;
  assign commit   = (state_r == ST_UPDATE) & out_free;
  assign is_ins   = (cmd_r == CMD_INSERT);

  // Match lines are one-hot at most: encode and select by OR
  always_comb begin
    hit       = 1'b0;
    hit_pos   = '0;
    hit_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_match[i]) begin
        hit       = 1'b1;
        hit_pos   = hit_pos | PW'(i);
        hit_value = hit_value | cell_value[i];
      end
    end
  end

  // Capacity clamped to 1 .. DEPTH
  always_comb begin
    cap_eff = MW'(cap_r);
    if (cap_eff == '0) begin
      cap_eff = MW'(1);
    end else if (cap_eff > MW'(DEPTH)) begin
      cap_eff = MW'(DEPTH);
    end
  end

  assign evict      = is_ins & ~hit & (MW'(count_r) >= cap_eff);
  assign head_value = is_ins ? value_r : hit_value;

  assign ctl.upd   = commit;
  assign ctl.hit   = hit;
  assign ctl.ins   = is_ins;
  assign ctl.evict = evict;

  // Recency chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      lkv_cell #(
        .IDX(g), .PW(PW), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .hit_pos   (hit_pos),
        .cmp_en    (accept),
        .cmp_key   (in_ch.key),
        .prev_valid(1'b1),
        .prev_key  (key_r),
        .prev_value(head_value),
        .valid_r   (cell_valid[g]),
        .key_r     (cell_key[g]),
        .value_r   (cell_value[g]),
        .match_r   (cell_match[g])
      );
    end else begin : g_body
      lkv_cell #(
        .IDX(g), .PW(PW), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .hit_pos   (hit_pos),
        .cmp_en    (accept),
        .cmp_key   (in_ch.key),
        .prev_valid(cell_valid[g-1]),
        .prev_key  (cell_key[g-1]),
        .prev_value(cell_value[g-1]),
        .valid_r   (cell_valid[g]),
        .key_r     (cell_key[g]),
        .value_r   (cell_value[g]),
        .match_r   (cell_match[g])
      );
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_UPDATE;
      ST_UPDATE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      if (commit && is_ins && !hit && !evict) begin
        count_r <= count_r + CW'(1);
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Latched transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_ch.cmd;
      key_r   <= in_ch.key;
      value_r <= in_ch.value;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r        <= hit;
      out_read_value_r <= (hit && !is_ins) ? hit_value : '0;
      out_evicted_r    <= evict;
      if (hit || is_ins) begin
        out_mru_key_r   <= key_r;
        out_mru_valid_r <= 1'b1;
      end else begin
        out_mru_key_r   <= cell_valid[0] ? cell_key[0] : '0;
        out_mru_valid_r <= cell_valid[0];
      end
    end
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.read_value = out_read_value_r;
  assign out_ch.evicted    = out_evicted_r;
  assign out_ch.mru_key    = out_mru_key_r;
  assign out_ch.mru_valid  = out_mru_valid_r;

endmodule

`default_nettype wire

### verif/lkv_lru_check.sv
module lkv_lru_check
  import lkv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  lkv_in_if               in_ch,
  lkv_out_if              out_ch,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_data,
  output int              fail_count,
  output int              pending_count
);

  localparam int SLOTS = DEPTH_DEF;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [63:0] mru_key;
    logic        mru_valid;
  } cache_resp_t;

  // Shadow copy of the cache contents
  logic [63:0] slot_key  [SLOTS];
  logic [31:0] slot_val  [SLOTS];
  logic        slot_used [SLOTS];
  logic [2:0]  slot_rank [SLOTS];
  logic [3:0]  used_count;
  logic [3:0]  capacity_reg;

  cache_resp_t answer_q [$];

  // Move slot s to rank 0; entries that were more recent age by one
  function automatic void make_most_recent(int s);
    logic [2:0] r;
    r = slot_rank[s];
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_rank[i] < r) slot_rank[i]++;
    end
    slot_rank[s] = '0;
  endfunction

  // Apply one lookup or insert to the shadow state, return its response
  function automatic cache_resp_t lru_access(lkv_cmd_t op, logic [63:0] key,
                                             logic [31:0] val);
    cache_resp_t res;
    int          found;
    int          victim;
    int          slot;
    int          limit;
    logic [2:0]  worst;
    res    = '0;
    found  = SLOTS;
    victim = SLOTS;
    slot   = SLOTS;
    worst  = '0;
    // capacity is clamped to 1 .. SLOTS
    limit  = (capacity_reg == 0) ? 1 : (int'(capacity_reg) > SLOTS) ? SLOTS
                                                                  : int'(capacity_reg);

    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_key[i] == key && found == SLOTS) found = i;
    end

    if (found < SLOTS) begin
      res.hit = 1'b1;
      if (op == CMD_GET) res.read_value = slot_val[found];
      else slot_val[found] = val;
      make_most_recent(found);
    end else if (op == CMD_INSERT) begin
      // full (or over a lowered capacity): drop the least recent entry
      if (int'(used_count) >= limit || int'(used_count) >= SLOTS) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && (victim == SLOTS || slot_rank[i] > worst)) begin
            victim = i;
            worst  = slot_rank[i];
          end
        end
        if (victim < SLOTS) begin
          slot_used[victim] = 1'b0;
          slot_rank[victim] = '0;
          if (used_count > 0) used_count--;
          res.evicted = 1'b1;
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (!slot_used[i] && slot == SLOTS) slot = i;
      end
      if (slot < SLOTS) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i]) slot_rank[i]++;
        end
        slot_key[slot]  = key;
        slot_val[slot]  = val;
        slot_used[slot] = 1'b1;
        slot_rank[slot] = '0;
        used_count++;
      end
    end

    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_rank[i] == 0) res.mru_key = slot_key[i];
    end
    res.mru_valid = (used_count > 0);
    return res;
  endfunction

  function automatic void compare_field(string field, logic [63:0] want,
                                        logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endfunction

  // Track config, check results against the oldest prediction, predict new ones
  always @(posedge clk) begin
    cache_resp_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_key[i]  = '0;
        slot_val[i]  = '0;
        slot_used[i] = 1'b0;
        slot_rank[i] = '0;
      end
      used_count   = '0;
      capacity_reg = CAP_RESET;
      fail_count   = 0;
      answer_q.delete();
    end else begin
      if (cfg_we) capacity_reg = cfg_data;

      if (out_ch.valid && out_ch.ready) begin
        if (answer_q.size() == 0) begin
          $error("result transaction with no transaction outstanding");
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          compare_field("hit", want.hit, out_ch.hit);
          compare_field("read_value", want.read_value, $unsigned(out_ch.read_value));
          compare_field("evicted", want.evicted, out_ch.evicted);
          compare_field("mru_key", want.mru_key, out_ch.mru_key);
          compare_field("mru_valid", want.mru_valid, out_ch.mru_valid);
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        answer_q.push_back(lru_access(lkv_cmd_t'(in_ch.cmd), in_ch.key,
                                      $unsigned(in_ch.value)));
      end
    end
    pending_count = answer_q.size();
  end

endmodule

### verif/lru_key_value_cache_top_tb.sv
module lru_key_value_cache_top_tb;
  import lkv_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int PHASE_ITEMS   = 110;
  localparam logic [63:0] KEY_ONES = '1;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_data;

  int fail_count;
  int pending_count;
  int cycles = 0;
  int n_inserts = 0;
  int n_gets = 0;
  int n_cfg_writes = 0;
  bit in_idle_en = 1'b1;
  bit out_idle_en = 1'b1;

  lkv_in_if  in_ch ();
  lkv_out_if out_ch ();

  lru_key_value_cache_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  lkv_lru_check i_lru_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #1 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[lru_key_value_cache_top] ERROR");
      $finish;
    end
  end

  // Result side: random stall before taking each transaction
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = out_idle_en ? $urandom_range(19, 0) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Send one transaction; valid stays high on return unless dropped later
  task automatic send_op(lkv_cmd_t op, logic [63:0] k, logic [31:0] v);
    int gap;
    gap = in_idle_en ? $urandom_range(19, 0) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= op;
    in_ch.key   <= k;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    if (op == CMD_GET) n_gets++;
    else n_inserts++;
  endtask

  // Let the cache drain, then drop in a new capacity
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic set_capacity(logic [3:0] cap);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we   <= 1'b0;
    n_cfg_writes++;
  endtask

  // Random traffic over a small key pool, with near-miss and extreme keys
  task automatic run_random_phase(logic [3:0] cap);
    logic [63:0] pool [12];
    int          pool_size;
    int          mode;
    int          pick;
    logic [63:0] k;
    logic [31:0] v;
    lkv_cmd_t    op;
    set_capacity(cap);
    mode        = $urandom_range(3, 0);
    in_idle_en  = (mode & 1) != 0;
    out_idle_en = (mode & 2) != 0;
    pool_size   = $urandom_range(12, 1);
    foreach (pool[i]) pool[i] = {$urandom, $urandom};
    repeat (PHASE_ITEMS) begin
      op   = ($urandom_range(1, 0) == 1) ? CMD_GET : CMD_INSERT;
      pick = $urandom_range(99, 0);
      if (pick < 75)      k = pool[$urandom_range(pool_size - 1, 0)];
      else if (pick < 85) k = pool[$urandom_range(pool_size - 1, 0)]
                              ^ (64'd1 << $urandom_range(63, 0));
      else if (pick < 95) k = {$urandom, $urandom};
      else if (pick < 97) k = '0;
      else                k = KEY_ONES;
      pick = $urandom_range(9, 0);
      case (pick)
        0:       v = 32'h8000_0000;
        1:       v = 32'h7fff_ffff;
        2:       v = '0;
        default: v = $urandom;
      endcase
      send_op(op, k, v);
    end
  endtask

  initial begin
    logic [3:0] caps [11];
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd   = CMD_INSERT;
    in_ch.key   = '0;
    in_ch.value = '0;
    caps = '{4'd1, 4'd0, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd15, 4'd5, 4'd1, 4'd7};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Get on an empty store
    send_op(CMD_GET, '0, 32'h1111_1111);

    // Capacity zero acts as one: second insert pushes out the first
    set_capacity(4'd0);
    send_op(CMD_INSERT, '0, 32'h8000_0000);
    send_op(CMD_INSERT, KEY_ONES, 32'h7fff_ffff);
    send_op(CMD_GET, '0, '0);
    send_op(CMD_GET, KEY_ONES, '0);

    // Capacity above depth: fill all slots, update, then evict at depth
    set_capacity(4'd15);
    send_op(CMD_INSERT, '0, 32'h1234_5678);
    send_op(CMD_GET, KEY_ONES, '0);
    for (int i = 1; i <= 6; i++) send_op(CMD_INSERT, 64'(i), 32'(i * 3));
    send_op(CMD_INSERT, KEY_ONES, 32'hffff_ffff);
    send_op(CMD_INSERT, 64'ha5a5_5a5a_0f0f_f0f0, 32'h5555_aaaa);
    send_op(CMD_GET, 64'd5, '0);
    send_op(CMD_GET, '0, '0);

    foreach (caps[i]) run_random_phase(caps[i]);

    drain();
    repeat (4) @(posedge clk);
    $display("Covered %0d transactions (%0d inserts, %0d gets) over %0d capacity writes,",
             n_inserts + n_gets, n_inserts, n_gets, n_cfg_writes);
    $display("including empty, clamped, lowered and full-depth capacity cases.");
    if (fail_count == 0) begin
      $display("[lru_key_value_cache_top] OK");
    end else begin
      $display("[lru_key_value_cache_top] ERROR");
    end
    $finish;
  end

endmodule
